[sv/tla_pkg.sv]
// ----------------------------------------------------------------------------
// tla_pkg - shared constants for the text line assembler
// Character codes, field widths and default line capacity.
// ----------------------------------------------------------------------------
package tla_pkg;

	localparam int CHAR_W = 8;
	localparam int LEN_W  = 6;

	localparam int LINE_CAPACITY_DEF = 64;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

endpackage

[sv/tla_intf.sv]
// ----------------------------------------------------------------------------
// tla_intf - valid/ready channels of the text line assembler
// Receive channel carries one character; line channel carries one character
// of a finished line with its length and last mark.
// ----------------------------------------------------------------------------
interface tla_rx_if;
	logic                      valid;
	logic                      ready;
	logic [tla_pkg::CHAR_W-1:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink   (input valid, input rx_char, output ready);
endinterface

interface tla_line_if;
	logic                      valid;
	logic                      ready;
	logic [tla_pkg::CHAR_W-1:0] line_char;
	logic [tla_pkg::LEN_W-1:0]  line_length;
	logic                      line_last;

	modport source (output valid, output line_char, output line_length, output line_last,
		input ready);
	modport sink   (input valid, input line_char, input line_length, input line_last,
		output ready);
endinterface

[sv/text_line_assembler_with_backspace.sv]
// ----------------------------------------------------------------------------
// text_line_assembler_with_backspace - command line builder with backspace
// Collects received characters into a line store, applies backspace, and on
// CR/LF/NUL emits the stored line one character per beat when enabled.
// ----------------------------------------------------------------------------
//  channel   dir   payload                              handshake
//  rx        in    rx_char[7:0]                         valid/ready
//  line      out   line_char[7:0] line_length[5:0] last valid/ready
//  cfg       in    cfg_wdata (deliver_enable)           cfg_we, no wait
//
//  With delivery enabled, a terminator of a non-empty line holds rx.ready
//  low while the line store is read out, one entry per cycle unless the line
//  channel stalls, through its single read port; the read data and the
//  output register form a two-deep pipe, so a stalled line channel pauses
//  the readout without losing a beat. Reset (arst_n low) empties the line
//  and clears deliver_enable; the store itself needs no clearing pass.
// ----------------------------------------------------------------------------
module text_line_assembler_with_backspace #(
	parameter int LINE_CAPACITY = tla_pkg::LINE_CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	tla_rx_if.sink             rx,
	tla_line_if.source         line,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	localparam int FILL_W = $clog2(LINE_CAPACITY);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_CAPACITY - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                       state_q;
	logic [FILL_W-1:0]          fill_q;
	logic [FILL_W-1:0]          len_q;
	logic [FILL_W-1:0]          rd_idx_q;
	logic                       deliver_enable_q;

	logic [tla_pkg::CHAR_W-1:0] mem [LINE_CAPACITY];

	// read stage
	logic                       rd_valid_s1;
	logic [tla_pkg::CHAR_W-1:0] rd_char_s1;
	logic [FILL_W-1:0]          rd_len_s1;
	logic                       rd_last_s1;

	// output register
	logic                       out_valid_q;
	logic [tla_pkg::CHAR_W-1:0] out_char_q;
	logic [tla_pkg::LEN_W-1:0]  out_len_q;
	logic                       out_last_q;

	logic rx_beat;
	logic is_term;
	logic is_bs;
	logic wr_en;
	logic load_out;
	logic rd_issue;
	logic rd_is_last;

	assign rx.ready  = (state_q == ST_IDLE);
	assign rx_beat   = rx.valid && rx.ready;
	assign is_term   = (rx.rx_char == tla_pkg::CH_CR) || (rx.rx_char == tla_pkg::CH_LF) ||
		(rx.rx_char == tla_pkg::CH_NUL);
	assign is_bs     = (rx.rx_char == tla_pkg::CH_BS);
	assign wr_en     = rx_beat && !is_term && !is_bs && (fill_q < FILL_MAX);

	assign load_out   = rd_valid_s1 && (!out_valid_q || line.ready);
	assign rd_issue   = (state_q == ST_READ) && (!rd_valid_s1 || load_out);
	assign rd_is_last = (rd_idx_q == (len_q - FILL_W'(1)));

	assign line.valid       = out_valid_q;
	assign line.line_char   = out_char_q;
	assign line.line_length = out_len_q;
	assign line.line_last   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_enable_q <= 1'b0;
		end else if (cfg_we) begin
			deliver_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rx_beat) begin
						if (is_bs) begin
							if (fill_q != '0) begin
								fill_q <= fill_q - FILL_W'(1);
							end
						end else if (is_term) begin
							// drop the line at once; len_q keeps it for readout
							if ((fill_q != '0) && deliver_enable_q) begin
								state_q  <= ST_READ;
								len_q    <= fill_q;
								rd_idx_q <= '0;
							end
							fill_q <= '0;
						end else if (wr_en) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				ST_READ: begin
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + FILL_W'(1);
						if (rd_is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// line store: write port in idle, read port during readout
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q] <= rx.rx_char;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_char_s1 <= mem[rd_idx_q];
			rd_len_s1  <= len_q;
			rd_last_s1 <= rd_is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (rd_issue) begin
			rd_valid_s1 <= 1'b1;
		end else if (load_out) begin
			rd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (line.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= rd_char_s1;
			out_len_q  <= tla_pkg::LEN_W'(rd_len_s1);
			out_last_q <= rd_last_s1;
		end
	end

endmodule

[sv/tla_checker.sv]
// ----------------------------------------------------------------------------
// tla_checker - port-level checks for the text line assembler
// Watches the receive and line channels and flags ordering slips.
// ----------------------------------------------------------------------------
module tla_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rx_valid,
	input logic                       rx_ready,
	input logic                       line_valid,
	input logic                       line_ready,
	input logic [tla_pkg::CHAR_W-1:0] line_char,
	input logic [tla_pkg::LEN_W-1:0]  line_length,
	input logic                       line_last
);

	logic                      mid_line_q;
	logic [tla_pkg::LEN_W-1:0] len_q;

	// track whether a line is partly delivered, and its length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_line_q <= 1'b0;
			len_q      <= '0;
		end else if (line_valid && line_ready) begin
			mid_line_q <= !line_last;
			len_q      <= line_length;
		end
	end

	a_line_hold: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_ready |=>
			line_valid && $stable(line_char) && $stable(line_length) && $stable(line_last))
		else $error("line beat changed while stalled");

	a_len_same: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && mid_line_q |-> line_length == len_q)
		else $error("line length changed within a line");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rx_ready) |-> $past(rx_valid))
		else $error("rx ready dropped without an accepted beat");

	a_ready_after_reset: assert property (@(posedge clk)
		!arst_n |=> rx_ready || !arst_n)
		else $error("rx ready low right after reset");

endmodule

bind text_line_assembler_with_backspace tla_checker u_tla_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.line_valid  (line.valid),
	.line_ready  (line.ready),
	.line_char   (line.line_char),
	.line_length (line.line_length),
	.line_last   (line.line_last)
);

[test/tla_line_checker.sv]
// ----------------------------------------------------------------------------
// tla_line_checker - scoreboard for the text line assembler
// Watches the receive, line and config ports, keeps its own copy of the line
// being typed, queues the beats that each terminator should release and
// compares every line beat against the oldest one owed.
// ----------------------------------------------------------------------------
module tla_line_checker #(
	parameter int LINE_CAPACITY = tla_pkg::LINE_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tla_rx_if    rx,
	tla_line_if  line,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   fail_count,
	output int   beats_owed,
	output int   beats_checked,
	output int   lines_checked
);

	typedef struct packed {
		logic [tla_pkg::CHAR_W-1:0] ch;
		logic [tla_pkg::LEN_W-1:0]  len;
		logic                       last;
	} line_beat_t;

	logic [tla_pkg::CHAR_W-1:0] typed_chars [LINE_CAPACITY];
	int                         typed_count;
	logic                       deliver_on;
	line_beat_t                 owed_beats [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] line check: %s", $time, what);
		fail_count++;
	endtask

	// Apply one received character to the typed line; queue the beats a
	// terminator releases.
	task automatic absorb_char(input logic [tla_pkg::CHAR_W-1:0] c);
		line_beat_t beat;
		if (c == tla_pkg::CH_BS) begin
			if (typed_count > 0)
				typed_count--;
		end else if (c == tla_pkg::CH_CR || c == tla_pkg::CH_LF || c == tla_pkg::CH_NUL) begin
			if (typed_count > 0 && deliver_on) begin
				for (int i = 0; i < typed_count; i++) begin
					beat.ch   = typed_chars[i];
					beat.len  = tla_pkg::LEN_W'(typed_count);
					beat.last = (i == typed_count - 1);
					owed_beats.push_back(beat);
				end
			end
			typed_count = 0;
		end else if (typed_count < LINE_CAPACITY - 1) begin
			typed_chars[typed_count] = c;
			typed_count++;
		end
		// a full line drops the character
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_beat_t want;
		if (!arst_n) begin
			typed_count   = 0;
			deliver_on    = 1'b0;
			fail_count    = 0;
			beats_checked = 0;
			lines_checked = 0;
			owed_beats.delete();
		end else begin
			if (cfg_we)
				deliver_on = cfg_wdata;
			if (line.valid && line.ready) begin
				if (owed_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat char %02h len %0d last %0b",
						line.line_char, line.line_length, line.line_last));
				end else begin
					want = owed_beats.pop_front();
					if (line.line_char !== want.ch)
						report_mismatch($sformatf("line_char got %02h want %02h",
							line.line_char, want.ch));
					if (line.line_length !== want.len)
						report_mismatch($sformatf("line_length got %0d want %0d",
							line.line_length, want.len));
					if (line.line_last !== want.last)
						report_mismatch($sformatf("line_last got %0b want %0b",
							line.line_last, want.last));
					beats_checked++;
					if (want.last)
						lines_checked++;
				end
			end
			if (rx.valid && rx.ready)
				absorb_char(rx.rx_char);
		end
		beats_owed <= owed_beats.size();
	end

endmodule

[test/text_line_assembler_with_backspace_tb.sv]
// ----------------------------------------------------------------------------
// text_line_assembler_with_backspace_tb - top of the line assembler test
// Types directed and random lines with backspaces, terminators, overfull
// lines and noise into the block under random idling on both sides, toggles
// line delivery between phases and lets the checker score every line beat.
// ----------------------------------------------------------------------------
module text_line_assembler_with_backspace_tb;

	localparam int LINE_CAP      = tla_pkg::LINE_CAPACITY_DEF;
	localparam int CHAR_TARGET   = 430;
	localparam int IDLE_PCT      = 31;
	localparam int SETTLE_CYCLES = LINE_CAP + 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 1_000_000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_wdata;

	int fail_count;
	int beats_owed;
	int beats_checked;
	int lines_checked;
	int chars_sent  = 0;
	int cycle_count = 0;
	int hold_req    = 0;
	bit idle_on     = 1'b1;

	tla_rx_if   rx_if ();
	tla_line_if line_if ();

	text_line_assembler_with_backspace #(
		.LINE_CAPACITY(LINE_CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_if),
		.line     (line_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	tla_line_checker #(
		.LINE_CAPACITY(LINE_CAP)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_if),
		.line         (line_if),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.beats_owed   (beats_owed),
		.beats_checked(beats_checked),
		.lines_checked(lines_checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed", cycle_count, beats_owed);
			$display("FAIL");
			$finish;
		end
	end

	// Line receiver: random stalls, plus a long hold-off on request.
	initial begin
		int hold_left;
		bit hold_done;
		hold_done = 1'b0;
		line_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = hold_req;
				while (hold_left > 0) begin
					line_if.ready <= 1'b0;
					hold_left--;
					@(posedge clk);
				end
			end
			if (idle_on && $urandom_range(0, 99) < IDLE_PCT)
				line_if.ready <= 1'b0;
			else
				line_if.ready <= 1'b1;
		end
	end

	// Leaves valid high after the beat so back-to-back characters need no
	// second assignment in the same step.
	task automatic send_char(input logic [tla_pkg::CHAR_W-1:0] c);
		if (idle_on) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				rx_if.valid   <= 1'b0;
				rx_if.rx_char <= tla_pkg::CHAR_W'($urandom_range(0, 255));
				@(posedge clk);
			end
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_char <= c;
		do @(posedge clk); while (!rx_if.ready);
		chars_sent++;
	endtask

	function automatic logic [tla_pkg::CHAR_W-1:0] plain_char();
		logic [tla_pkg::CHAR_W-1:0] c;
		do c = tla_pkg::CHAR_W'($urandom_range(0, 255));
		while (c == tla_pkg::CH_BS || c == tla_pkg::CH_CR || c == tla_pkg::CH_LF ||
			c == tla_pkg::CH_NUL);
		return c;
	endfunction

	function automatic logic [tla_pkg::CHAR_W-1:0] pick_terminator();
		case ($urandom_range(0, 2))
			0: return tla_pkg::CH_CR;
			1: return tla_pkg::CH_LF;
			default: return tla_pkg::CH_NUL;
		endcase
	endfunction

	task automatic send_line(input int body_len, input int bs_pct);
		for (int i = 0; i < body_len; i++) begin
			if ($urandom_range(0, 99) < bs_pct)
				send_char(tla_pkg::CH_BS);
			else
				send_char(plain_char());
		end
		send_char(pick_terminator());
		// CR LF style pair: the second terminator ends an empty line
		if ($urandom_range(0, 3) == 0)
			send_char(tla_pkg::CH_LF);
	endtask

	// Type past capacity, then back up and add a few more before ending.
	task automatic send_overfull_line();
		int body;
		body = $urandom_range(LINE_CAP, LINE_CAP + 12);
		for (int i = 0; i < body; i++)
			send_char(plain_char());
		repeat ($urandom_range(1, 2)) send_char(tla_pkg::CH_BS);
		repeat ($urandom_range(0, 3)) send_char(plain_char());
		send_char(pick_terminator());
	endtask

	task automatic send_random_block();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			send_overfull_line();
		end else if (pick < 85) begin
			send_line($urandom_range(1, 10), 12);
		end else begin
			repeat ($urandom_range(1, 6))
				send_char(tla_pkg::CHAR_W'($urandom_range(0, 255)));
		end
	endtask

	// Hold the sender until every owed beat is out and the block has settled.
	task automatic drain();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (beats_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_delivery(input logic on);
		drain();
		cfg_wdata <= on;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		rx_if.valid   <= 1'b0;
		rx_if.rx_char <= '0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// delivery is off out of reset: this line is cleared silently
		send_char("a");
		send_char("b");
		send_char(tla_pkg::CH_CR);
		send_char(tla_pkg::CH_BS);
		send_char(tla_pkg::CH_LF);
		set_delivery(1'b1);
		send_char(8'h01);
		send_char(8'hFF);
		send_char(8'h7F);
		send_char(tla_pkg::CH_BS);
		send_char(8'h80);
		send_char(tla_pkg::CH_LF);
		// backspace the line down to nothing, then end it
		send_char("q");
		send_char(tla_pkg::CH_BS);
		send_char(tla_pkg::CH_BS);
		send_char(tla_pkg::CH_CR);
		send_char("Z");
		send_char(tla_pkg::CH_NUL);
		send_char(tla_pkg::CH_CR);

		send_overfull_line();
		while (chars_sent < 150)
			send_random_block();

		// receiver holds off while lines keep coming, so the input stalls
		drain();
		hold_req = HOLD_CYCLES;
		repeat (3) send_line($urandom_range(12, 20), 0);

		set_delivery(1'b0);
		send_overfull_line();
		while (chars_sent < 220)
			send_random_block();

		set_delivery(1'b1);
		idle_on = 1'b0;
		send_overfull_line();
		while (chars_sent < 300)
			send_random_block();
		idle_on = 1'b1;
		while (chars_sent < CHAR_TARGET)
			send_random_block();

		drain();
		$display("typed %0d characters; %0d beats in %0d lines scored", chars_sent,
			beats_checked, lines_checked);
		$display("delivery on and off, backspace, empty and overfull lines, long line stall");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
